// ----- hw/rtl/qfts_pkg.sv -----
`default_nettype none
package qfts_pkg;

	localparam int DEPTH = 8;
	localparam int WORD_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_ZERO = '0;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic [WORD_W-1:0] EMPTY_DATA = '1;
	localparam logic [WORD_W-1:0] ENQ_DATA = '0;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/queue_from_two_stacks_core.sv -----
// channel | handshake              | fields
// in      | in_valid / in_stall    | req_type, value
// out     | out_valid / out_stall  | result_data, status
//
// Enqueue: result registered on acceptance. Dequeue from a non-empty outbox: one memory read.
// Dequeue that refills the outbox from n inbox words: paced by the
// single inbox read port moving one word per cycle; each word moves only once.
// Reset clears both fill counts; the stores need no clearing pass.
// A stalled result holds in the output register; a new request is taken once the core is
// idle and that register is free or being drained in the same cycle.
`default_nettype none
module queue_from_two_stacks_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                req_type,
	input  wire logic signed [qfts_pkg::WORD_W-1:0]  value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [qfts_pkg::WORD_W-1:0]       result_data,
	output logic [1:0]                               status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_XFER
	} state_t;

	state_t                        state_q;
	logic [qfts_pkg::CNT_W-1:0]    icnt_q;
	logic [qfts_pkg::CNT_W-1:0]    ocnt_q;
	logic                          xfer_last_s1;
	logic                          out_valid_q;
	logic [qfts_pkg::WORD_W-1:0]   result_data_q;
	logic [1:0]                    status_q;

	qfts_pkg::ram_req_t            inbox_req;
	qfts_pkg::ram_req_t            outbox_req;
	logic [qfts_pkg::WORD_W-1:0]   inbox_rdata;
	logic [qfts_pkg::WORD_W-1:0]   outbox_rdata;

	logic accept;
	logic inbox_full;
	logic inbox_empty;
	logic outbox_empty;
	logic out_load;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign inbox_full = (icnt_q == qfts_pkg::CNT_FULL);
	assign inbox_empty = (icnt_q == qfts_pkg::CNT_ZERO);
	assign outbox_empty = (ocnt_q == qfts_pkg::CNT_ZERO);

	// a result word enters the output register this cycle
	assign out_load = (state_q == ST_IDLE && accept &&
			(req_type == qfts_pkg::REQ_ENQ || (inbox_empty && outbox_empty))) ||
		(state_q == ST_POP) ||
		(state_q == ST_XFER && xfer_last_s1);

	qfts_ram u_inbox (
		.clk   (clk),
		.req   (inbox_req),
		.rdata (inbox_rdata)
	);

	qfts_ram u_outbox (
		.clk   (clk),
		.req   (outbox_req),
		.rdata (outbox_rdata)
	);

	always_comb begin
		inbox_req = '0;
		outbox_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == qfts_pkg::REQ_ENQ) begin
						inbox_req.we = !inbox_full;
						inbox_req.waddr = qfts_pkg::ADDR_W'(icnt_q);
						inbox_req.wdata = value;
					end else if (!outbox_empty) begin
						outbox_req.re = 1'b1;
						outbox_req.raddr = qfts_pkg::ADDR_W'(ocnt_q - qfts_pkg::CNT_ONE);
					end else if (!inbox_empty) begin
						inbox_req.re = 1'b1;
						inbox_req.raddr = qfts_pkg::ADDR_W'(icnt_q - qfts_pkg::CNT_ONE);
					end
				end
			end
			ST_XFER: begin
				// the oldest word (inbox bottom) goes straight out, never to the outbox
				if (!xfer_last_s1) begin
					outbox_req.we = 1'b1;
					outbox_req.waddr = qfts_pkg::ADDR_W'(ocnt_q);
					outbox_req.wdata = inbox_rdata;
					inbox_req.re = 1'b1;
					inbox_req.raddr = qfts_pkg::ADDR_W'(icnt_q - qfts_pkg::CNT_ONE);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			icnt_q <= '0;
			ocnt_q <= '0;
			xfer_last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			result_data_q <= '0;
			status_q <= qfts_pkg::STAT_OK;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == qfts_pkg::REQ_ENQ) begin
							result_data_q <= qfts_pkg::ENQ_DATA;
							if (inbox_full) begin
								status_q <= qfts_pkg::STAT_FULL;
							end else begin
								status_q <= qfts_pkg::STAT_OK;
								icnt_q <= icnt_q + qfts_pkg::CNT_ONE;
							end
						end else if (inbox_empty && outbox_empty) begin
							result_data_q <= qfts_pkg::EMPTY_DATA;
							status_q <= qfts_pkg::STAT_EMPTY;
						end else if (!outbox_empty) begin
							ocnt_q <= ocnt_q - qfts_pkg::CNT_ONE;
							state_q <= ST_POP;
						end else begin
							icnt_q <= icnt_q - qfts_pkg::CNT_ONE;
							xfer_last_s1 <= (icnt_q == qfts_pkg::CNT_ONE);
							state_q <= ST_XFER;
						end
					end
				end
				ST_POP: begin
					result_data_q <= outbox_rdata;
					status_q <= qfts_pkg::STAT_OK;
					state_q <= ST_IDLE;
				end
				ST_XFER: begin
					if (xfer_last_s1) begin
						result_data_q <= inbox_rdata;
						status_q <= qfts_pkg::STAT_OK;
						xfer_last_s1 <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						// advance: one word lands in the outbox, next one is read
						ocnt_q <= ocnt_q + qfts_pkg::CNT_ONE;
						icnt_q <= icnt_q - qfts_pkg::CNT_ONE;
						xfer_last_s1 <= (icnt_q == qfts_pkg::CNT_ONE);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_data = result_data_q;
	assign status = status_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		icnt_q <= qfts_pkg::CNT_FULL && ocnt_q <= qfts_pkg::CNT_FULL)
		else $error("stack count beyond depth");

	a_xfer_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XFER && !xfer_last_s1) |->
		(icnt_q != qfts_pkg::CNT_ZERO && ocnt_q < qfts_pkg::CNT_FULL))
		else $error("transfer step without inbox word or outbox room");

	a_busy_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP || state_q == ST_XFER) |-> !out_valid_q)
		else $error("output register busy while a dequeue is pending");

	a_xfer_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == qfts_pkg::REQ_DEQ && outbox_empty && !inbox_empty) |=>
		(state_q == ST_XFER && ocnt_q == qfts_pkg::CNT_ZERO))
		else $error("refill started with a non-empty outbox");

endmodule
`default_nettype wire

// ----- hw/rtl/qfts_ram.sv -----
`default_nettype none
module qfts_ram (
	input  wire logic                          clk,
	input  wire qfts_pkg::ram_req_t            req,
	output logic [qfts_pkg::WORD_W-1:0]        rdata
);

	logic [qfts_pkg::WORD_W-1:0] mem_q [qfts_pkg::DEPTH];
	logic [qfts_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
